// File: src/rfct_pkg.sv
`timescale 1ns / 1ps

package rfct_pkg;

   // Width of one grid coordinate as it travels on the ports.
   localparam int COORD_W = 6;
   // Width of the signed line error term and of its doubled form.
   localparam int ERR_W   = 8;
   localparam int E2_W    = ERR_W + 1;
   // Span along y is kept negated, one bit wider than a coordinate.
   localparam int SPANY_W = COORD_W + 1;

   localparam int DEFAULT_GRID_SIZE = 64;

   // Packed word widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 2'd1;

   localparam logic [COORD_W-1:0] ORIGIN_RESET = 6'd32;

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // Sequencer commands to the walk unit.
   typedef struct packed {
      logic load;
      logic advance;
   } walk_ctrl_type;

   // Walk unit status back to the sequencer.
   typedef struct packed {
      logic      at_end;
      logic      next_is_end;
      coord_type cell_x;
      coord_type cell_y;
   } walk_stat_type;

   // Saturate a coordinate to the largest cell index of the grid.
   function automatic coord_type clamp_coord(input coord_type value,
                                             input coord_type max_cell);
      coord_type result;
      result = (value > max_cell) ? max_cell : value;
      return result;
   endfunction

endpackage

// File: src/ray_free_cell_tracer.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | tdata: target_x, target_y
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: cell_x, cell_y; tlast: last_cell
// csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// A ray is loaded, then emits one cell per step of the walk, max(|dx|, |dy|)
// cells and at most 63; the sequencer is back in idle at the edge that hands over
// the final cell, and the single step unit of the walk makes each step.
// A ray whose hit equals the origin emits no cell and returns straight to idle.
// Reset is synchronous and active high; origins return to cell (32, 32).
// A stalled rsp word holds the walk; req_tready is low for the whole walk.
module ray_free_cell_tracer #(
   parameter int GRID_SIZE = rfct_pkg::DEFAULT_GRID_SIZE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] target_x, [11:6] target_y, [15:12] zero
   input  logic [rfct_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] cell_x, [11:6] cell_y, [15:12] zero
   output logic [rfct_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rfct_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfct_pkg::COORD_W-1:0]       csr_data
);

   // Largest cell index reachable on this grid, capped by the coordinate width.
   localparam int MaxCellInt = (GRID_SIZE - 1 > (1 << rfct_pkg::COORD_W) - 1) ?
                               (1 << rfct_pkg::COORD_W) - 1 : GRID_SIZE - 1;
   localparam rfct_pkg::coord_type MaxCell = rfct_pkg::COORD_W'(MaxCellInt);

   rfct_pkg::state_type      state_ff, state_in;
   rfct_pkg::coord_type      origin_x_ff, origin_x_in;
   rfct_pkg::coord_type      origin_y_ff, origin_y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rfct_pkg::coord_type      rsp_x_ff, rsp_x_in;
   rfct_pkg::coord_type      rsp_y_ff, rsp_y_in;
   logic                     rsp_last_ff, rsp_last_in;

   rfct_pkg::walk_ctrl_type  walk_ctrl;
   rfct_pkg::walk_stat_type  walk_stat;
   logic                     req_accept;
   logic                     slot_free;
   logic                     emit;

   assign req_accept = req_tvalid && req_tready;
   // The output register can take a new word when empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   rfct_walk_unit u_walk (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (walk_ctrl),
      .origin_x (rfct_pkg::clamp_coord(origin_x_ff, MaxCell)),
      .origin_y (rfct_pkg::clamp_coord(origin_y_ff, MaxCell)),
      .target_x (rfct_pkg::clamp_coord(req_tdata[rfct_pkg::COORD_W-1:0], MaxCell)),
      .target_y (rfct_pkg::clamp_coord(req_tdata[2*rfct_pkg::COORD_W-1:rfct_pkg::COORD_W],
                                       MaxCell)),
      .stat     (walk_stat)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfct_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = rfct_pkg::ST_WALK;
            end
         end
         rfct_pkg::ST_WALK: begin
            // The walk ends once the final free cell is handed over, or at
            // once when the hit cell is the origin itself.
            if (walk_stat.at_end || (emit && walk_stat.next_is_end)) begin
               state_in = rfct_pkg::ST_IDLE;
            end
         end
         default: state_in = rfct_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready        = 1'b0;
      emit              = 1'b0;
      walk_ctrl.load    = 1'b0;
      walk_ctrl.advance = 1'b0;
      unique case (state_ff)
         rfct_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            walk_ctrl.load = req_tvalid;
         end
         rfct_pkg::ST_WALK: begin
            emit              = !walk_stat.at_end && slot_free;
            walk_ctrl.advance = emit;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Output word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = walk_stat.cell_x;
         rsp_y_in     = walk_stat.cell_y;
         rsp_last_in  = walk_stat.next_is_end;
      end
   end

   // Origin registers; writes to indexes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rfct_pkg::CSR_ORIGIN_X: origin_x_in = csr_data;
            rfct_pkg::CSR_ORIGIN_Y: origin_y_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfct_pkg::ST_IDLE;
         origin_x_ff  <= rfct_pkg::ORIGIN_RESET;
         origin_y_ff  <= rfct_pkg::ORIGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rfct_pkg::RSP_DATA_W - 2*rfct_pkg::COORD_W){1'b0}},
                        rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   // An accepted ray always starts a walk.
   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rfct_pkg::ST_WALK))
      else $error("accepted ray did not start a walk");

   // Handing over the final cell of a ray returns the sequencer to idle.
   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (emit && walk_stat.next_is_end) |=> (state_ff == rfct_pkg::ST_IDLE))
      else $error("walk continued past its final cell");

   // Cells are only produced while a walk is in progress.
   a_emit_in_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rfct_pkg::ST_WALK))
      else $error("output word appeared outside a walk");

   // A walk standing on its hit cell emits nothing more.
   a_end_no_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfct_pkg::ST_WALK && walk_stat.at_end) |-> !emit)
      else $error("hit cell was emitted");

endmodule

// File: src/rfct_walk_unit.sv
`timescale 1ns / 1ps

// Bresenham walk registers and the single step datapath that advances them.
module rfct_walk_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  rfct_pkg::walk_ctrl_type     ctrl,
   input  rfct_pkg::coord_type         origin_x,
   input  rfct_pkg::coord_type         origin_y,
   input  rfct_pkg::coord_type         target_x,
   input  rfct_pkg::coord_type         target_y,
   output rfct_pkg::walk_stat_type     stat
);

   rfct_pkg::coord_type                      walk_x_ff, walk_x_in;
   rfct_pkg::coord_type                      walk_y_ff, walk_y_in;
   rfct_pkg::coord_type                      end_x_ff, end_x_in;
   rfct_pkg::coord_type                      end_y_ff, end_y_in;
   rfct_pkg::coord_type                      span_x_ff, span_x_in;
   logic signed [rfct_pkg::SPANY_W-1:0]      span_y_neg_ff, span_y_neg_in;
   logic signed [rfct_pkg::ERR_W-1:0]        line_error_ff, line_error_in;
   logic                                     step_x_down_ff, step_x_down_in;
   logic                                     step_y_down_ff, step_y_down_in;

   logic signed [rfct_pkg::E2_W-1:0]         err_x2;
   logic                                     move_x;
   logic                                     move_y;
   logic signed [rfct_pkg::ERR_W-1:0]        err_add_x;
   logic signed [rfct_pkg::ERR_W-1:0]        err_add_y;
   rfct_pkg::coord_type                      step_x;
   rfct_pkg::coord_type                      step_y;
   rfct_pkg::coord_type                      load_span_x;
   rfct_pkg::coord_type                      load_span_y;

   // One step: compare the doubled error against both spans.
   always_comb begin
      err_x2    = {line_error_ff, 1'b0};
      move_x    = err_x2 >= rfct_pkg::E2_W'(span_y_neg_ff);
      move_y    = err_x2 <= $signed({3'b000, span_x_ff});
      err_add_x = move_x ? rfct_pkg::ERR_W'(span_y_neg_ff) : '0;
      err_add_y = move_y ? $signed({2'b00, span_x_ff}) : '0;
      if (!move_x) begin
         step_x = walk_x_ff;
      end else if (step_x_down_ff) begin
         step_x = walk_x_ff - 1'b1;
      end else begin
         step_x = walk_x_ff + 1'b1;
      end
      if (!move_y) begin
         step_y = walk_y_ff;
      end else if (step_y_down_ff) begin
         step_y = walk_y_ff - 1'b1;
      end else begin
         step_y = walk_y_ff + 1'b1;
      end
   end

   always_comb begin
      load_span_x = (target_x > origin_x) ? target_x - origin_x : origin_x - target_x;
      load_span_y = (target_y > origin_y) ? target_y - origin_y : origin_y - target_y;
   end

   always_comb begin
      walk_x_in      = walk_x_ff;
      walk_y_in      = walk_y_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      span_x_in      = span_x_ff;
      span_y_neg_in  = span_y_neg_ff;
      line_error_in  = line_error_ff;
      step_x_down_in = step_x_down_ff;
      step_y_down_in = step_y_down_ff;
      if (ctrl.load) begin
         walk_x_in      = origin_x;
         walk_y_in      = origin_y;
         end_x_in       = target_x;
         end_y_in       = target_y;
         span_x_in      = load_span_x;
         span_y_neg_in  = -$signed({1'b0, load_span_y});
         line_error_in  = $signed({2'b00, load_span_x}) - $signed({2'b00, load_span_y});
         step_x_down_in = target_x < origin_x;
         step_y_down_in = target_y < origin_y;
      end else if (ctrl.advance) begin
         walk_x_in     = step_x;
         walk_y_in     = step_y;
         line_error_in = line_error_ff + err_add_x + err_add_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff      <= '0;
         walk_y_ff      <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         span_x_ff      <= '0;
         span_y_neg_ff  <= '0;
         line_error_ff  <= '0;
         step_x_down_ff <= 1'b0;
         step_y_down_ff <= 1'b0;
      end else begin
         walk_x_ff      <= walk_x_in;
         walk_y_ff      <= walk_y_in;
         end_x_ff       <= end_x_in;
         end_y_ff       <= end_y_in;
         span_x_ff      <= span_x_in;
         span_y_neg_ff  <= span_y_neg_in;
         line_error_ff  <= line_error_in;
         step_x_down_ff <= step_x_down_in;
         step_y_down_ff <= step_y_down_in;
      end
   end

   always_comb begin
      stat.at_end      = (walk_x_ff == end_x_ff) && (walk_y_ff == end_y_ff);
      stat.next_is_end = (step_x == end_x_ff) && (step_y == end_y_ff);
      stat.cell_x      = walk_x_ff;
      stat.cell_y      = walk_y_ff;
   end

endmodule
